@@ hdl/granule_map_first_fit_allocator_unit_defines.svh @@
// Assertion macros used by the checker file of the allocator.
`ifndef GRANULE_MAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define GRANULE_MAP_FIRST_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/gfa_pkg.sv @@
package gfa_pkg;

    localparam int GRANULES_DEF      = 256;
    localparam int GRANULE_BYTES_DEF = 16;

    localparam int OPCODE_W = 1;
    localparam int REQ_W    = 13;
    localparam int OFF_W    = 12;
    localparam int STATUS_W = 2;
    localparam int FREED_W  = 13;
    localparam int TAG_W    = 2;
    // Wide enough for the largest request plus the round-up term.
    localparam int DIV_W    = 14;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_ZERO_SIZE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } status_t;

    typedef logic [TAG_W-1:0] tag_t;

    // Smallest run tag from 1 to 3 that differs from both neighbors.
    function automatic tag_t pick_tag(input tag_t left, input tag_t right);
        tag_t tag;
        tag = 2'd1;
        if (left == 2'd1 || right == 2'd1) begin
            tag = 2'd2;
            if (left == 2'd2 || right == 2'd2) begin
                tag = 2'd3;
            end
        end
        return tag;
    endfunction

endpackage

@@ hdl/granule_map_first_fit_allocator_unit.sv @@
// Granule map allocator. Requests arrive on the s_ channel (valid/ready):
// s_opcode selects allocate or free, s_request_bytes is the allocate size and
// s_free_offset the byte offset to release. Each request gives exactly one
// item on the m_ channel: m_status, m_alloc_offset and m_freed_bytes.
// After aresetn is released the block zeroes every entry of the tag memory;
// s_ready stays low during that sweep.
// Requests are handled one at a time. Sizes and offsets are first divided by
// the granule size with a reciprocal multiply. An allocate then scans the tag
// memory one granule per cycle until the first fit is found, and writes the
// run one granule per cycle. A free reads the granule and its left neighbor
// (no neighbor at granule 0), then clears the run one granule per cycle.
// s_ready rises the cycle after the result is loaded, and the tag memory
// walk sets the request rate.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and worked on, and only its final hand-off to
// the output register waits until the old result has been taken.
module granule_map_first_fit_allocator_unit #(
    parameter int GRANULES      = gfa_pkg::GRANULES_DEF,
    parameter int GRANULE_BYTES = gfa_pkg::GRANULE_BYTES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [gfa_pkg::OPCODE_W-1:0] s_opcode,
    input  logic [gfa_pkg::REQ_W-1:0]    s_request_bytes,
    input  logic [gfa_pkg::OFF_W-1:0]    s_free_offset,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gfa_pkg::STATUS_W-1:0] m_status,
    output logic [gfa_pkg::OFF_W-1:0]    m_alloc_offset,
    output logic [gfa_pkg::FREED_W-1:0]  m_freed_bytes
);

    localparam int AW     = $clog2(GRANULES);
    localparam int CW     = $clog2(GRANULES + 1);
    localparam int REGION = GRANULES * GRANULE_BYTES;
    localparam int UW     = $clog2(REGION + 1);
    localparam int SW     = ((UW > gfa_pkg::REQ_W) ? UW : gfa_pkg::REQ_W) + 1;
    localparam int DW     = gfa_pkg::DIV_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DIV, S_SCAN, S_RIGHT, S_AWR,
        S_FPREV, S_FCUR, S_FCHK, S_FCLR, S_FMUL, S_FSUB, S_DONE
    } state_t;

    state_t                         state_reg;
    logic [gfa_pkg::OPCODE_W-1:0]   op_reg;
    logic [CW-1:0]                  need_reg;
    logic [CW-1:0]                  run_reg;
    logic [CW-1:0]                  issue_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [AW-1:0]                  start_reg;
    logic [AW-1:0]                  idx_reg;
    logic [AW-1:0]                  pidx_reg;
    logic [AW-1:0]                  wptr_reg;
    logic                           pend_reg;
    logic                           redge_reg;
    gfa_pkg::tag_t                  left_reg;
    gfa_pkg::tag_t                  prev_tag_reg;
    gfa_pkg::tag_t                  tag_reg;
    gfa_pkg::tag_t                  first_reg;
    logic [UW-1:0]                  used_reg;
    logic [UW-1:0]                  nb_reg;
    gfa_pkg::status_t               res_status_reg;
    logic [gfa_pkg::OFF_W-1:0]      res_offset_reg;
    logic [gfa_pkg::FREED_W-1:0]    res_freed_reg;
    logic                           m_valid_reg;
    gfa_pkg::status_t               m_status_reg;
    logic [gfa_pkg::OFF_W-1:0]      m_alloc_offset_reg;
    logic [gfa_pkg::FREED_W-1:0]    m_freed_bytes_reg;

    // Tag memory: one write and one read port, registered read data.
    gfa_pkg::tag_t                  tag_mem [GRANULES];
    gfa_pkg::tag_t                  ram_rdata;
    logic                           ram_we;
    logic                           ram_re;
    logic [AW-1:0]                  ram_waddr;
    logic [AW-1:0]                  ram_raddr;
    gfa_pkg::tag_t                  ram_wdata;

    logic                           accept;
    logic [DW-1:0]                  div_dividend;
    logic [DW-1:0]                  div_quotient;
    logic                           div_done;
    logic [SW-1:0]                  budget_sum;
    logic                           fchk_clear;
    logic                           fclr_hit;
    logic                           scan_found;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign div_dividend = (s_opcode == gfa_pkg::OP_ALLOC)
        ? (DW'(s_request_bytes) + DW'(GRANULE_BYTES - 1))
        : DW'(s_free_offset);

    gfa_div #(
        .DIVISOR (GRANULE_BYTES)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (div_dividend),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign budget_sum = SW'(used_reg) + SW'(s_request_bytes);

    // The left neighbor tag of a free lives in prev_tag_reg.
    assign fchk_clear = (ram_rdata != 2'd0)
        && !((idx_reg != '0) && (ram_rdata == prev_tag_reg));
    assign fclr_hit   = pend_reg && (ram_rdata == first_reg);
    assign scan_found = pend_reg && (ram_rdata == 2'd0) && ((run_reg + 1'b1) == need_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = wptr_reg;
        ram_raddr = issue_reg[AW-1:0];
        ram_wdata = '0;
        case (state_reg)
            S_INIT: begin
                ram_we = 1'b1;
            end
            S_SCAN: begin
                ram_re = (issue_reg != CW'(GRANULES));
            end
            S_AWR: begin
                ram_we    = 1'b1;
                ram_wdata = tag_reg;
            end
            S_FPREV: begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg - 1'b1;
            end
            S_FCUR: begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg;
            end
            S_FCHK: begin
                ram_we    = fchk_clear;
                ram_waddr = idx_reg;
                ram_re    = fchk_clear && (idx_reg != AW'(GRANULES - 1));
                ram_raddr = idx_reg + 1'b1;
            end
            S_FCLR: begin
                ram_we    = fclr_hit;
                ram_waddr = pidx_reg;
                ram_re    = fclr_hit && (pidx_reg != AW'(GRANULES - 1));
                ram_raddr = pidx_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            tag_mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            ram_rdata <= tag_mem[ram_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            wptr_reg    <= '0;
            used_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // A result waiting in S_DONE reloads the output register itself.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT: begin
                    wptr_reg <= wptr_reg + 1'b1;
                    if (wptr_reg == AW'(GRANULES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= s_opcode;
                        res_offset_reg <= '0;
                        res_freed_reg  <= '0;
                        res_status_reg <= gfa_pkg::ST_OK;
                        if (s_opcode == gfa_pkg::OP_FREE) begin
                            state_reg <= S_DIV;
                        end else if (s_request_bytes == '0) begin
                            res_status_reg <= gfa_pkg::ST_ZERO_SIZE;
                            state_reg      <= S_DONE;
                        end else if (budget_sum > SW'(REGION)) begin
                            res_status_reg <= gfa_pkg::ST_NO_SPACE;
                            state_reg      <= S_DONE;
                        end else begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (op_reg == gfa_pkg::OP_ALLOC) begin
                            // The budget check bounds the granule count by GRANULES.
                            need_reg  <= CW'(div_quotient);
                            nb_reg    <= UW'(div_quotient * GRANULE_BYTES);
                            issue_reg <= '0;
                            run_reg   <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SCAN;
                        end else if (32'(div_quotient) >= 32'(GRANULES)) begin
                            res_status_reg <= gfa_pkg::ST_BAD_FREE;
                            state_reg      <= S_DONE;
                        end else begin
                            idx_reg   <= AW'(div_quotient);
                            state_reg <= (div_quotient == '0) ? S_FCUR : S_FPREV;
                        end
                    end
                end
                S_SCAN: begin
                    // Reads run one granule ahead of the granule being examined.
                    if (issue_reg != CW'(GRANULES)) begin
                        issue_reg <= issue_reg + 1'b1;
                        pend_reg  <= 1'b1;
                        pidx_reg  <= issue_reg[AW-1:0];
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        prev_tag_reg <= ram_rdata;
                        if (ram_rdata == 2'd0) begin
                            if (run_reg == '0) begin
                                start_reg <= pidx_reg;
                                left_reg  <= (pidx_reg == '0) ? 2'd1 : prev_tag_reg;
                            end
                            run_reg <= run_reg + 1'b1;
                        end else begin
                            run_reg <= '0;
                        end
                        if (scan_found) begin
                            redge_reg <= (pidx_reg == AW'(GRANULES - 1));
                            state_reg <= S_RIGHT;
                        end else if (pidx_reg == AW'(GRANULES - 1)) begin
                            res_status_reg <= gfa_pkg::ST_NO_SPACE;
                            state_reg      <= S_DONE;
                        end
                    end
                end
                S_RIGHT: begin
                    tag_reg        <= gfa_pkg::pick_tag(left_reg,
                                          redge_reg ? 2'd1 : ram_rdata);
                    res_offset_reg <= gfa_pkg::OFF_W'(start_reg * GRANULE_BYTES);
                    wptr_reg       <= start_reg;
                    cnt_reg        <= '0;
                    state_reg      <= S_AWR;
                end
                S_AWR: begin
                    wptr_reg <= wptr_reg + 1'b1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if ((cnt_reg + 1'b1) == need_reg) begin
                        used_reg  <= used_reg + nb_reg;
                        state_reg <= S_DONE;
                    end
                end
                S_FPREV: begin
                    state_reg <= S_FCUR;
                end
                S_FCUR: begin
                    prev_tag_reg <= ram_rdata;
                    state_reg    <= S_FCHK;
                end
                S_FCHK: begin
                    if ((idx_reg != '0) && (ram_rdata == prev_tag_reg)) begin
                        res_status_reg <= gfa_pkg::ST_BAD_FREE;
                        state_reg      <= S_DONE;
                    end else if (ram_rdata == 2'd0) begin
                        state_reg <= S_DONE;
                    end else begin
                        first_reg <= ram_rdata;
                        cnt_reg   <= CW'(1);
                        pend_reg  <= (idx_reg != AW'(GRANULES - 1));
                        pidx_reg  <= idx_reg + 1'b1;
                        state_reg <= S_FCLR;
                    end
                end
                S_FCLR: begin
                    if (fclr_hit) begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        pend_reg <= (pidx_reg != AW'(GRANULES - 1));
                        pidx_reg <= pidx_reg + 1'b1;
                    end else begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_FMUL;
                    end
                end
                S_FMUL: begin
                    nb_reg    <= UW'(cnt_reg * GRANULE_BYTES);
                    state_reg <= S_FSUB;
                end
                S_FSUB: begin
                    used_reg      <= (nb_reg > used_reg) ? '0 : (used_reg - nb_reg);
                    res_freed_reg <= gfa_pkg::FREED_W'(nb_reg);
                    state_reg     <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_status_reg       <= res_status_reg;
                        m_alloc_offset_reg <= res_offset_reg;
                        m_freed_bytes_reg  <= res_freed_reg;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_offset = m_alloc_offset_reg;
    assign m_freed_bytes  = m_freed_bytes_reg;

endmodule

@@ hdl/gfa_div.sv @@
module gfa_div #(
    parameter int DIVISOR = gfa_pkg::GRANULE_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [gfa_pkg::DIV_W-1:0] dividend,
    output logic [gfa_pkg::DIV_W-1:0] quotient,
    output logic                      done
);

    localparam int DW = gfa_pkg::DIV_W;
    localparam int LW = $clog2(DIVISOR);
    localparam int SH = DW + LW;
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;
    // Scaled reciprocal rounded up; the quotient is exact for every dividend
    // below 2**DW, and the reciprocal fits in DW + 1 bits.
    localparam longint RECIP =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

    logic [PW-1:0] product;
    logic [DW-1:0] quo_next;
    logic [DW-1:0] quo_reg;
    logic          done_reg;

    assign product  = PW'(dividend) * PW'(RECIP);
    assign quo_next = DW'(product >> SH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
        if (start) begin
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ hdl/gfa_checker.sv @@
`include "granule_map_first_fit_allocator_unit_defines.svh"

module gfa_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [gfa_pkg::OPCODE_W-1:0] s_opcode,
    input logic [gfa_pkg::REQ_W-1:0]    s_request_bytes,
    input logic [gfa_pkg::OFF_W-1:0]    s_free_offset,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [gfa_pkg::STATUS_W-1:0] m_status,
    input logic [gfa_pkg::OFF_W-1:0]    m_alloc_offset,
    input logic [gfa_pkg::FREED_W-1:0]  m_freed_bytes
);

    // A stalled result item must hold until it is taken.
    `GFA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_alloc_offset) && $stable(m_freed_bytes), "result item changed while stalled")

    // Failed requests carry no offset and release nothing.
    `GFA_ASSERT_NOW(a_fail_zero, aclk, aresetn, m_valid && (m_status != gfa_pkg::ST_OK), (m_alloc_offset == '0) && (m_freed_bytes == '0), "failed request reports a nonzero field")

    // Released bytes only come from a successful free, which has no offset.
    `GFA_ASSERT_NOW(a_freed_ok, aclk, aresetn, m_valid && (m_freed_bytes != '0), (m_status == gfa_pkg::ST_OK) && (m_alloc_offset == '0), "freed bytes on a non-free result")

    // The block works on one request at a time.
    `GFA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "second request taken while busy")

endmodule

bind granule_map_first_fit_allocator_unit gfa_checker u_gfa_checker (.*);

@@ bench/granule_map_first_fit_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module granule_map_first_fit_allocator_unit_tb;

    localparam int N_GRAN      = gfa_pkg::GRANULES_DEF;
    localparam int GRAN_BYTES  = gfa_pkg::GRANULE_BYTES_DEF;
    localparam int REGION      = N_GRAN * GRAN_BYTES;
    localparam int RANDOM_REQS = 1330;
    localparam int CALM_FROM   = 1150;
    localparam int LONG_HOLD   = 600;
    localparam int DRAIN_WAIT  = 600;

    typedef struct {
        logic [gfa_pkg::OPCODE_W-1:0] opcode;
        logic [gfa_pkg::REQ_W-1:0]    size_bytes;
        logic [gfa_pkg::OFF_W-1:0]    offset;
    } alloc_req_t;

    typedef struct {
        gfa_pkg::status_t            status;
        logic [gfa_pkg::OFF_W-1:0]   offset;
        logic [gfa_pkg::FREED_W-1:0] freed;
    } alloc_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [gfa_pkg::OPCODE_W-1:0] s_opcode = '0;
    logic [gfa_pkg::REQ_W-1:0]    s_request_bytes = '0;
    logic [gfa_pkg::OFF_W-1:0]    s_free_offset = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [gfa_pkg::STATUS_W-1:0] m_status;
    logic [gfa_pkg::OFF_W-1:0]    m_alloc_offset;
    logic [gfa_pkg::FREED_W-1:0]  m_freed_bytes;

    alloc_req_t    pending_requests[$];
    alloc_result_t pending_results[$];
    alloc_req_t    cur_req;

    // Shadow of the allocator: one tag per granule and the byte total in use.
    gfa_pkg::tag_t granule_tags[N_GRAN] = '{default: '0};
    int            bytes_in_use = 0;

    int fail_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;

    granule_map_first_fit_allocator_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_bytes (s_request_bytes),
        .s_free_offset   (s_free_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_alloc_offset  (m_alloc_offset),
        .m_freed_bytes   (m_freed_bytes)
    );

    always #1 aclk = ~aclk;

    // Applies one request to the shadow map and returns the answer it gives.
    function automatic alloc_result_t apply_request(input alloc_req_t r);
        alloc_result_t res;
        int need, run, start, pos, idx, cnt, freed;
        gfa_pkg::tag_t left, right, tag;
        res.status = gfa_pkg::ST_OK;
        res.offset = '0;
        res.freed  = '0;
        if (r.opcode == gfa_pkg::OP_ALLOC) begin
            if (r.size_bytes == 0) begin
                res.status = gfa_pkg::ST_ZERO_SIZE;
            end else if (bytes_in_use + int'(r.size_bytes) > REGION) begin
                res.status = gfa_pkg::ST_NO_SPACE;
            end else begin
                need = (int'(r.size_bytes) + GRAN_BYTES - 1) / GRAN_BYTES;
                pos = -1;
                run = 0;
                start = 0;
                for (int i = 0; i < N_GRAN && pos < 0; i++) begin
                    if (granule_tags[i] == 2'd0) begin
                        if (run == 0) start = i;
                        run++;
                        if (run == need) pos = start;
                    end else begin
                        run = 0;
                    end
                end
                if (pos < 0) begin
                    res.status = gfa_pkg::ST_NO_SPACE;
                end else begin
                    left  = (pos == 0) ? 2'd1 : granule_tags[pos-1];
                    right = (pos + need >= N_GRAN) ? 2'd1 : granule_tags[pos+need];
                    tag = 2'd1;
                    while (tag == left || tag == right) tag++;
                    for (int i = 0; i < need; i++) granule_tags[pos+i] = tag;
                    bytes_in_use += need * GRAN_BYTES;
                    res.offset = gfa_pkg::OFF_W'(pos * GRAN_BYTES);
                end
            end
        end else begin
            idx = int'(r.offset) / GRAN_BYTES;
            cnt = 0;
            if (idx >= N_GRAN) begin
                res.status = gfa_pkg::ST_BAD_FREE;
            end else if (idx > 0 && granule_tags[idx] == granule_tags[idx-1]) begin
                res.status = gfa_pkg::ST_BAD_FREE;
            end else begin
                tag = granule_tags[idx];
                if (tag != 2'd0) begin
                    for (int i = idx; i < N_GRAN && granule_tags[i] == tag; i++) begin
                        granule_tags[i] = 2'd0;
                        cnt++;
                    end
                end
                freed = cnt * GRAN_BYTES;
                bytes_in_use = (freed > bytes_in_use) ? 0 : bytes_in_use - freed;
                res.freed = gfa_pkg::FREED_W'(freed);
            end
        end
        return res;
    endfunction

    // The field that the operation ignores gets random content.
    task automatic queue_request(input logic [gfa_pkg::OPCODE_W-1:0] op, input int nbytes,
                                 input int off);
        alloc_req_t r;
        r.opcode = op;
        r.size_bytes = (op == gfa_pkg::OP_ALLOC) ? gfa_pkg::REQ_W'(nbytes)
                                                 : gfa_pkg::REQ_W'($urandom);
        r.offset = (op == gfa_pkg::OP_FREE) ? gfa_pkg::OFF_W'(off)
                                            : gfa_pkg::OFF_W'($urandom);
        pending_requests.push_back(r);
    endtask

    // Driver: predicts each accepted item, then offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_request(cur_req));
            end
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        send_wait = $urandom_range(0, 2);
                        s_valid <= 1'b0;
                    end else begin
                        cur_req = pending_requests.pop_front();
                        s_valid <= 1'b1;
                        s_opcode <= cur_req.opcode;
                        s_request_bytes <= cur_req.size_bytes;
                        s_free_offset <= cur_req.offset;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result and drives m_ready with random stalls.
    always @(posedge aclk) begin
        alloc_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, status %0d offset %0d freed %0d",
                             $time, m_status, m_alloc_offset, m_freed_bytes);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, m_status);
                        fail_count++;
                    end
                    if (m_alloc_offset !== want.offset) begin
                        $display("%0t: alloc_offset expected %0d, actual %0d",
                                 $time, want.offset, m_alloc_offset);
                        fail_count++;
                    end
                    if (m_freed_bytes !== want.freed) begin
                        $display("%0t: freed_bytes expected %0d, actual %0d",
                                 $time, want.freed, m_freed_bytes);
                        fail_count++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_wait = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int run_starts[$];
        int pick;
        int free_pct;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, starting from an empty map.
        queue_request(gfa_pkg::OP_ALLOC, 0, 0);
        queue_request(gfa_pkg::OP_FREE, 0, 0);        // free granule at index zero
        queue_request(gfa_pkg::OP_FREE, 0, 17);       // free granule after a free one
        queue_request(gfa_pkg::OP_ALLOC, 1, 0);       // left edge of the map
        queue_request(gfa_pkg::OP_ALLOC, 16, 0);
        queue_request(gfa_pkg::OP_ALLOC, 17, 0);
        queue_request(gfa_pkg::OP_ALLOC, 4096, 0);    // total too large
        queue_request(gfa_pkg::OP_ALLOC, 8191, 0);
        queue_request(gfa_pkg::OP_FREE, 0, 63);       // inside a run
        queue_request(gfa_pkg::OP_FREE, 0, 40);       // unaligned run start
        queue_request(gfa_pkg::OP_FREE, 0, 32);       // free granule after a tagged one
        queue_request(gfa_pkg::OP_FREE, 0, 4095);
        queue_request(gfa_pkg::OP_ALLOC, 4064, 0);    // runs to the right edge, map full
        queue_request(gfa_pkg::OP_ALLOC, 1, 0);
        queue_request(gfa_pkg::OP_FREE, 0, 16);
        queue_request(gfa_pkg::OP_FREE, 0, 0);
        queue_request(gfa_pkg::OP_ALLOC, 48, 0);
        queue_request(gfa_pkg::OP_ALLOC, 32, 0);      // both neighbors differ, third tag
        queue_request(gfa_pkg::OP_FREE, 0, 0);
        queue_request(gfa_pkg::OP_FREE, 0, 32);
        queue_request(gfa_pkg::OP_ALLOC, 4096, 0);    // whole region in one run
        queue_request(gfa_pkg::OP_FREE, 0, 0);
        queue_request(gfa_pkg::OP_FREE, 0, 4080);

        // Random part: mostly frees of live runs and allocations that fit.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            while (pending_requests.size() >= 2) @(negedge aclk);
            if (n == 300 || n == 900) hold_off_req = 1'b1;
            if (n == CALM_FROM) calm = 1'b1;
            free_pct = (bytes_in_use > REGION / 2) ? 60 : 35;
            if ($urandom_range(0, 99) < free_pct) begin
                run_starts.delete();
                for (int g = 0; g < N_GRAN; g++) begin
                    if (granule_tags[g] != 2'd0 &&
                        (g == 0 || granule_tags[g] != granule_tags[g-1])) begin
                        run_starts.push_back(g);
                    end
                end
                if (run_starts.size() > 0 && $urandom_range(0, 9) < 8) begin
                    pick = run_starts[$urandom_range(0, run_starts.size() - 1)];
                    queue_request(gfa_pkg::OP_FREE, 0,
                                  pick * GRAN_BYTES + $urandom_range(0, GRAN_BYTES - 1));
                end else begin
                    queue_request(gfa_pkg::OP_FREE, 0, $urandom_range(0, 4095));
                end
            end else begin
                case ($urandom_range(0, 19))
                    0:       queue_request(gfa_pkg::OP_ALLOC, 0, 0);
                    1:       queue_request(gfa_pkg::OP_ALLOC,
                                           $urandom_range(REGION + 1, 8191), 0);
                    2, 3:    queue_request(gfa_pkg::OP_ALLOC,
                                           $urandom_range(1025, REGION), 0);
                    4, 5, 6: queue_request(gfa_pkg::OP_ALLOC, $urandom_range(257, 1024), 0);
                    default: queue_request(gfa_pkg::OP_ALLOC, $urandom_range(1, 256), 0);
                endcase
            end
        end

        while (pending_requests.size() > 0 || s_valid) @(negedge aclk);
        while (pending_results.size() > 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (fail_count == 0) begin
            $display("granule_map_first_fit_allocator_unit test passed");
        end else begin
            $display("granule_map_first_fit_allocator_unit test failed");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("granule_map_first_fit_allocator_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/gfa_pkg.sv
hdl/gfa_div.sv
hdl/granule_map_first_fit_allocator_unit.sv
hdl/gfa_checker.sv
bench/granule_map_first_fit_allocator_unit_tb.sv
